// ===== src/ccc_pkg.sv =====
`default_nettype none
package ccc_pkg;

    localparam int MAX_TAPS    = 1024;
    localparam int ADDR_W      = $clog2(MAX_TAPS);
    localparam int TAP_CNT_W   = ADDR_W + 1;
    localparam int SAMPLE_BITS = 16;
    localparam int IDX_W       = 10;
    localparam int FUNC_W      = 2;
    localparam int CFG_W       = 11;
    localparam int CORR_BITS   = 43;
    localparam int PROD_W      = 2 * SAMPLE_BITS;
    localparam int IN_W        = ((IDX_W + 2 * SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_W       = ((2 * CORR_BITS + 7) / 8) * 8;

    localparam logic [CFG_W-1:0]  TAP_COUNT_RESET = CFG_W'(1024);

    localparam logic [FUNC_W-1:0] FUNC_LOAD   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SAMPLE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FLUSH  = 2'd2;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [CORR_BITS-1:0]   corr_t;

    typedef struct packed {
        logic valid;
        logic zero;
        logic last;
    } mac_ctrl_t;

endpackage
`default_nettype wire

// ===== src/ccc_mac.sv =====
`default_nettype none
module ccc_mac
    import ccc_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      clear,
    input  wire mac_ctrl_t ctrl,
    input  wire sample_t   x_re,
    input  wire sample_t   x_im,
    input  wire sample_t   r_re,
    input  wire sample_t   r_im,
    output corr_t          acc_re,
    output corr_t          acc_im,
    output logic           done
);

    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [PROD_W:0]   term_t;

    sample_t   xr_m;
    sample_t   xi_m;
    mac_ctrl_t ctrl_reg;
    prod_t     p_rr_reg;
    prod_t     p_ii_reg;
    prod_t     p_ir_reg;
    prod_t     p_ri_reg;
    term_t     term_re;
    term_t     term_im;
    corr_t     acc_re_reg;
    corr_t     acc_im_reg;
    logic      done_reg;

    assign xr_m = ctrl.zero ? '0 : x_re;
    assign xi_m = ctrl.zero ? '0 : x_im;

    always_ff @(posedge aclk) begin
        p_rr_reg <= xr_m * r_re;
        p_ii_reg <= xi_m * r_im;
        p_ir_reg <= xi_m * r_re;
        p_ri_reg <= xr_m * r_im;
    end

    assign term_re = {p_rr_reg[PROD_W-1], p_rr_reg} + {p_ii_reg[PROD_W-1], p_ii_reg};
    assign term_im = {p_ir_reg[PROD_W-1], p_ir_reg} - {p_ri_reg[PROD_W-1], p_ri_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= '0;
            done_reg <= 1'b0;
        end else begin
            ctrl_reg <= ctrl;
            done_reg <= ctrl_reg.valid && ctrl_reg.last;
        end
    end

    always_ff @(posedge aclk) begin
        if (clear) begin
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end else if (ctrl_reg.valid) begin
            acc_re_reg <= acc_re_reg
                + {{(CORR_BITS-PROD_W-1){term_re[PROD_W]}}, term_re};
            acc_im_reg <= acc_im_reg
                + {{(CORR_BITS-PROD_W-1){term_im[PROD_W]}}, term_im};
        end
    end

    assign acc_re = acc_re_reg;
    assign acc_im = acc_im_reg;
    assign done   = done_reg;

endmodule
`default_nettype wire

// ===== src/complex_cross_correlator_core.sv =====
`default_nettype none
// Complex matched filter: each sample item returns one item holding
// sum over k of x[t-(n-1)+k] * conj(ref[k]) with n = tap_count (0 acts as 1,
// values above 1024 act as 1024), exact in 43-bit sums. Load the reference
// with load items first; the delay line starts at zero after reset and flush
// items push zero samples to produce the tail. Load items and code-3 items
// leave the block idle; a sample or flush item runs through the one
// shared complex multiply-accumulate that walks all taps through the single
// read port of the reference and sample memories. The next item is taken
// while a finished result waits on the output. The user must write tap_count
// only while the block is idle; the block itself does not enforce it.
module complex_cross_correlator_core
    import ccc_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [CFG_W-1:0] cfg_data,   // tap_count
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [IN_W-1:0]  s_tdata,    // tap_index, data_re, data_im, zero pad
    input  wire logic [FUNC_W-1:0] s_tuser,   // func
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [OUT_W-1:0]      m_tdata     // corr_re, corr_im, zero pad
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    localparam logic [TAP_CNT_W-1:0] FULL_COUNT = TAP_CNT_W'(MAX_TAPS);

    logic [SAMPLE_BITS*2-1:0] ref_mem  [MAX_TAPS];
    logic [SAMPLE_BITS*2-1:0] hist_mem [MAX_TAPS];
    logic [SAMPLE_BITS*2-1:0] ref_rd_reg;
    logic [SAMPLE_BITS*2-1:0] hist_rd_reg;

    state_t               state_reg;
    logic [CFG_W-1:0]     tap_count_reg;
    logic [ADDR_W-1:0]    head_reg;
    logic [ADDR_W-1:0]    newest_reg;
    logic [TAP_CNT_W-1:0] fill_reg;
    logic [TAP_CNT_W-1:0] taps_reg;
    logic [ADDR_W-1:0]    k_reg;
    logic                 m_valid_reg;
    corr_t                out_re_reg;
    corr_t                out_im_reg;
    mac_ctrl_t            rd_ctrl_reg;

    logic [IDX_W-1:0]     in_idx;
    sample_t              in_re;
    sample_t              in_im;
    logic                 s_accept;
    logic                 is_load;
    logic                 is_push;
    logic [SAMPLE_BITS*2-1:0] push_word;
    logic [TAP_CNT_W-1:0] active_taps;
    logic [TAP_CNT_W-1:0] back;
    logic [ADDR_W-1:0]    hist_addr;
    mac_ctrl_t            issue;
    logic                 mac_clear;
    corr_t                acc_re;
    corr_t                acc_im;
    logic                 mac_done;

    assign in_idx = s_tdata[IDX_W-1:0];
    assign in_re  = s_tdata[IDX_W +: SAMPLE_BITS];
    assign in_im  = s_tdata[IDX_W+SAMPLE_BITS +: SAMPLE_BITS];

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign is_load   = (s_tuser == FUNC_LOAD);
    assign is_push   = (s_tuser == FUNC_SAMPLE) || (s_tuser == FUNC_FLUSH);
    assign push_word = (s_tuser == FUNC_FLUSH) ? '0 : {in_im, in_re};
    assign mac_clear = s_accept && is_push;

    always_comb begin
        if (tap_count_reg == '0) begin
            active_taps = TAP_CNT_W'(1);
        end else if (32'(tap_count_reg) > 32'(MAX_TAPS)) begin
            active_taps = FULL_COUNT;
        end else begin
            active_taps = TAP_CNT_W'(tap_count_reg);
        end
    end

    assign back      = taps_reg - TAP_CNT_W'(1) - {1'b0, k_reg};
    assign hist_addr = newest_reg - back[ADDR_W-1:0];

    always_comb begin
        issue.valid = (state_reg == ST_RUN);
        issue.zero  = (back >= fill_reg);
        issue.last  = (back == '0);
    end

    always_ff @(posedge aclk) begin
        if (s_accept && is_load && (32'(in_idx) < 32'(MAX_TAPS))) begin
            ref_mem[ADDR_W'(in_idx)] <= {in_im, in_re};
        end
        ref_rd_reg <= ref_mem[k_reg];
    end

    always_ff @(posedge aclk) begin
        if (s_accept && is_push) begin
            hist_mem[head_reg] <= push_word;
        end
        hist_rd_reg <= hist_mem[hist_addr];
    end

    ccc_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (mac_clear),
        .ctrl    (rd_ctrl_reg),
        .x_re    (hist_rd_reg[SAMPLE_BITS-1:0]),
        .x_im    (hist_rd_reg[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .r_re    (ref_rd_reg[SAMPLE_BITS-1:0]),
        .r_im    (ref_rd_reg[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .acc_re  (acc_re),
        .acc_im  (acc_im),
        .done    (mac_done)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            tap_count_reg <= TAP_COUNT_RESET;
            head_reg      <= '0;
            newest_reg    <= '0;
            fill_reg      <= '0;
            taps_reg      <= TAP_CNT_W'(1);
            k_reg         <= '0;
            m_valid_reg   <= 1'b0;
            rd_ctrl_reg   <= '0;
        end else begin
            rd_ctrl_reg <= issue;
            if (cfg_valid && cfg_ready) begin
                tap_count_reg <= cfg_data;
            end
            if (m_valid_reg && m_tready && (state_reg != ST_DONE)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_accept && is_push) begin
                        newest_reg <= head_reg;
                        head_reg   <= head_reg + ADDR_W'(1);
                        if (fill_reg != FULL_COUNT) begin
                            fill_reg <= fill_reg + TAP_CNT_W'(1);
                        end
                        taps_reg  <= active_taps;
                        k_reg     <= '0;
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (issue.last) begin
                        state_reg <= ST_DRAIN;
                    end else begin
                        k_reg <= k_reg + ADDR_W'(1);
                    end
                end
                ST_DRAIN: begin
                    if (mac_done) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!m_valid_reg || m_tready) begin
                        out_re_reg  <= acc_re;
                        out_im_reg  <= acc_im;
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(OUT_W-2*CORR_BITS){1'b0}}, out_im_reg, out_re_reg};

endmodule
`default_nettype wire
